// ===== hdl/segment_intersection_top_defines.svh =====
// Assertion macros for the segment intersection block.
// Used by segment_intersection_top; no other dependencies.
`ifndef SEGMENT_INTERSECTION_TOP_DEFINES_SVH
`define SEGMENT_INTERSECTION_TOP_DEFINES_SVH

// implication checked outside reset
`define SGI_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked on every edge, reset included
`define SGI_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/sgi_pkg.sv =====
// Types and constants of the segment intersection block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package sgi_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int PARAM_FRAC_BITS = 16;

   localparam int DIFF_W = COORD_WIDTH + 1;       // coordinate differences
   localparam int PROD_W = 2 * DIFF_W;            // cross-product terms
   localparam int DEN_W  = PROD_W + 1;            // denominator and numerators
   localparam int NUM_W  = DEN_W + COORD_WIDTH;   // t numerator times |direction|
   localparam int STEPS  = (PARAM_FRAC_BITS > COORD_WIDTH) ? PARAM_FRAC_BITS : COORD_WIDTH;
   localparam int COORD_PAD = STEPS - COORD_WIDTH;

   localparam int LANES  = 4;
   localparam int LANE_S = 0;   // s fraction
   localparam int LANE_T = 1;   // t fraction
   localparam int LANE_X = 2;   // x offset quotient
   localparam int LANE_Y = 3;   // y offset quotient

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] a_start_x;
      logic signed [COORD_WIDTH-1:0] a_start_y;
      logic signed [COORD_WIDTH-1:0] a_end_x;
      logic signed [COORD_WIDTH-1:0] a_end_y;
      logic signed [COORD_WIDTH-1:0] b_start_x;
      logic signed [COORD_WIDTH-1:0] b_start_y;
      logic signed [COORD_WIDTH-1:0] b_end_x;
      logic signed [COORD_WIDTH-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic                              hit;
      logic        [PARAM_FRAC_BITS-1:0] frac_on_b;
      logic        [PARAM_FRAC_BITS-1:0] frac_on_a;
      logic signed [COORD_WIDTH-1:0]     cross_x;
      logic signed [COORD_WIDTH-1:0]     cross_y;
   } rsp_type;

   // one restoring-division lane: partial remainder and dividend/quotient shifter
   typedef struct packed {
      logic [DEN_W-1:0] r;
      logic [STEPS-1:0] sh;
   } lane_type;

   typedef struct packed {
      logic                   hit;
      logic [DEN_W-1:0]       d;
      logic [COORD_WIDTH-1:0] p0x;
      logic [COORD_WIDTH-1:0] p0y;
      logic                   ax_neg;
      logic                   ay_neg;
      lane_type [LANES-1:0]   lane;
   } cell_type;

endpackage

// ===== hdl/sgi_front.sv =====
// Front pipeline: differences, cross products, sign tests and offset products.
// Depends on sgi_pkg.
`timescale 1ns / 1ps
module sgi_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sgi_pkg::req_type  req_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output sgi_pkg::cell_type dn_data
);

   localparam int CW = sgi_pkg::COORD_WIDTH;
   localparam int DW = sgi_pkg::DIFF_W;
   localparam int PW = sgi_pkg::PROD_W;
   localparam int NW = sgi_pkg::DEN_W;
   localparam int MW = sgi_pkg::NUM_W;

   logic [5:1] v_ff;
   logic [5:1] rdy;

   // stage 1
   logic signed [DW-1:0] s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff, s1_wx_ff, s1_wy_ff;
   logic [CW-1:0] s1_p0x_ff, s1_p0y_ff;
   // stage 2
   logic signed [PW-1:0] s2_axby_ff, s2_bxay_ff, s2_axwy_ff, s2_aywx_ff, s2_bxwy_ff, s2_bywx_ff;
   logic signed [DW-1:0] s2_ax_ff, s2_ay_ff;
   logic [CW-1:0] s2_p0x_ff, s2_p0y_ff;
   // stage 3
   logic signed [NW-1:0] s3_den_ff, s3_sn_ff, s3_tn_ff;
   logic signed [DW-1:0] s3_ax_ff, s3_ay_ff;
   logic [CW-1:0] s3_p0x_ff, s3_p0y_ff;
   // stage 4
   logic          s4_hit_ff, s4_axn_ff, s4_ayn_ff;
   logic [NW-1:0] s4_d_ff, s4_sn_ff, s4_tn_ff;
   logic [CW-1:0] s4_axm_ff, s4_aym_ff, s4_p0x_ff, s4_p0y_ff;
   // stage 5
   logic          s5_hit_ff, s5_axn_ff, s5_ayn_ff;
   logic [NW-1:0] s5_d_ff, s5_sn_ff, s5_tn_ff;
   logic [MW-1:0] s5_nx_ff, s5_ny_ff;
   logic [CW-1:0] s5_p0x_ff, s5_p0y_ff;

   // stage 4 combinational
   logic                 sn_neg, tn_neg, den_neg, den_pos, cs, ct, hit_in;
   logic signed [NW-1:0] sn_abs, tn_abs, sd, td;
   logic signed [DW-1:0] ax_abs, ay_abs;

   assign rdy[5]    = !v_ff[5] || dn_ready;
   assign rdy[4]    = !v_ff[4] || rdy[5];
   assign rdy[3]    = !v_ff[3] || rdy[4];
   assign rdy[2]    = !v_ff[2] || rdy[3];
   assign rdy[1]    = !v_ff[1] || rdy[2];
   assign req_ready = rdy[1];
   assign dn_valid  = v_ff[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[1]) v_ff[1] <= req_valid;
         if (rdy[2]) v_ff[2] <= v_ff[1];
         if (rdy[3]) v_ff[3] <= v_ff[2];
         if (rdy[4]) v_ff[4] <= v_ff[3];
         if (rdy[5]) v_ff[5] <= v_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1] && req_valid) begin
         s1_ax_ff  <= {req_data.a_end_x[CW-1], req_data.a_end_x}
                    - {req_data.a_start_x[CW-1], req_data.a_start_x};
         s1_ay_ff  <= {req_data.a_end_y[CW-1], req_data.a_end_y}
                    - {req_data.a_start_y[CW-1], req_data.a_start_y};
         s1_bx_ff  <= {req_data.b_end_x[CW-1], req_data.b_end_x}
                    - {req_data.b_start_x[CW-1], req_data.b_start_x};
         s1_by_ff  <= {req_data.b_end_y[CW-1], req_data.b_end_y}
                    - {req_data.b_start_y[CW-1], req_data.b_start_y};
         s1_wx_ff  <= {req_data.a_start_x[CW-1], req_data.a_start_x}
                    - {req_data.b_start_x[CW-1], req_data.b_start_x};
         s1_wy_ff  <= {req_data.a_start_y[CW-1], req_data.a_start_y}
                    - {req_data.b_start_y[CW-1], req_data.b_start_y};
         s1_p0x_ff <= req_data.a_start_x;
         s1_p0y_ff <= req_data.a_start_y;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2] && v_ff[1]) begin
         s2_axby_ff <= s1_ax_ff * s1_by_ff;
         s2_bxay_ff <= s1_bx_ff * s1_ay_ff;
         s2_axwy_ff <= s1_ax_ff * s1_wy_ff;
         s2_aywx_ff <= s1_ay_ff * s1_wx_ff;
         s2_bxwy_ff <= s1_bx_ff * s1_wy_ff;
         s2_bywx_ff <= s1_by_ff * s1_wx_ff;
         s2_ax_ff   <= s1_ax_ff;
         s2_ay_ff   <= s1_ay_ff;
         s2_p0x_ff  <= s1_p0x_ff;
         s2_p0y_ff  <= s1_p0y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3] && v_ff[2]) begin
         s3_den_ff <= {s2_axby_ff[PW-1], s2_axby_ff} - {s2_bxay_ff[PW-1], s2_bxay_ff};
         s3_sn_ff  <= {s2_axwy_ff[PW-1], s2_axwy_ff} - {s2_aywx_ff[PW-1], s2_aywx_ff};
         s3_tn_ff  <= {s2_bxwy_ff[PW-1], s2_bxwy_ff} - {s2_bywx_ff[PW-1], s2_bywx_ff};
         s3_ax_ff  <= s2_ax_ff;
         s3_ay_ff  <= s2_ay_ff;
         s3_p0x_ff <= s2_p0x_ff;
         s3_p0y_ff <= s2_p0y_ff;
      end
   end

   // sign conflict, negation and range test
   always_comb begin
      sn_neg  = s3_sn_ff[NW-1];
      tn_neg  = s3_tn_ff[NW-1];
      den_neg = s3_den_ff[NW-1];
      den_pos = !den_neg && (s3_den_ff != '0);
      cs      = (sn_neg && den_pos) || (!sn_neg && (s3_sn_ff != '0) && den_neg);
      ct      = (tn_neg && den_pos) || (!tn_neg && (s3_tn_ff != '0) && den_neg);
      sn_abs  = sn_neg ? -s3_sn_ff : s3_sn_ff;
      tn_abs  = tn_neg ? -s3_tn_ff : s3_tn_ff;
      sd      = sn_neg ? -s3_den_ff : s3_den_ff;
      td      = tn_neg ? -s3_den_ff : s3_den_ff;
      hit_in  = !cs && !ct && (sn_abs < sd) && (tn_abs < td);
      ax_abs  = s3_ax_ff[DW-1] ? -s3_ax_ff : s3_ax_ff;
      ay_abs  = s3_ay_ff[DW-1] ? -s3_ay_ff : s3_ay_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[4] && v_ff[3]) begin
         s4_hit_ff <= hit_in;
         s4_d_ff   <= sd;
         s4_sn_ff  <= sn_abs;
         s4_tn_ff  <= tn_abs;
         s4_axm_ff <= ax_abs[CW-1:0];
         s4_aym_ff <= ay_abs[CW-1:0];
         s4_axn_ff <= s3_ax_ff[DW-1];
         s4_ayn_ff <= s3_ay_ff[DW-1];
         s4_p0x_ff <= s3_p0x_ff;
         s4_p0y_ff <= s3_p0y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5] && v_ff[4]) begin
         s5_hit_ff <= s4_hit_ff;
         s5_d_ff   <= s4_d_ff;
         s5_sn_ff  <= s4_sn_ff;
         s5_tn_ff  <= s4_tn_ff;
         s5_nx_ff  <= MW'(s4_tn_ff) * MW'(s4_axm_ff);
         s5_ny_ff  <= MW'(s4_tn_ff) * MW'(s4_aym_ff);
         s5_axn_ff <= s4_axn_ff;
         s5_ayn_ff <= s4_ayn_ff;
         s5_p0x_ff <= s4_p0x_ff;
         s5_p0y_ff <= s4_p0y_ff;
      end
   end

   // seed the division chain; high product bits are below d since t < 1
   always_comb begin
      dn_data.hit    = s5_hit_ff;
      dn_data.d      = s5_d_ff;
      dn_data.p0x    = s5_p0x_ff;
      dn_data.p0y    = s5_p0y_ff;
      dn_data.ax_neg = s5_axn_ff;
      dn_data.ay_neg = s5_ayn_ff;
      dn_data.lane[sgi_pkg::LANE_S].r  = s5_sn_ff;
      dn_data.lane[sgi_pkg::LANE_S].sh = '0;
      dn_data.lane[sgi_pkg::LANE_T].r  = s5_tn_ff;
      dn_data.lane[sgi_pkg::LANE_T].sh = '0;
      dn_data.lane[sgi_pkg::LANE_X].r  = s5_nx_ff[MW-1:CW];
      dn_data.lane[sgi_pkg::LANE_X].sh =
         sgi_pkg::STEPS'(s5_nx_ff[CW-1:0]) << sgi_pkg::COORD_PAD;
      dn_data.lane[sgi_pkg::LANE_Y].r  = s5_ny_ff[MW-1:CW];
      dn_data.lane[sgi_pkg::LANE_Y].sh =
         sgi_pkg::STEPS'(s5_ny_ff[CW-1:0]) << sgi_pkg::COORD_PAD;
   end

endmodule

// ===== hdl/sgi_div_cell.sv =====
// One restoring-division step for all four lanes, with its pipeline register.
// Depends on sgi_pkg.
`timescale 1ns / 1ps
module sgi_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  sgi_pkg::cell_type up_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output sgi_pkg::cell_type dn_data
);

   localparam int NW = sgi_pkg::DEN_W;
   localparam int ST = sgi_pkg::STEPS;

   logic              valid_ff;
   sgi_pkg::cell_type data_ff;
   sgi_pkg::cell_type data_in;

   always_comb begin
      logic [NW:0] trial;
      logic        take;
      data_in = up_data;
      for (int l = 0; l < sgi_pkg::LANES; l++) begin
         trial = {up_data.lane[l].r, up_data.lane[l].sh[ST-1]};
         take  = trial >= {1'b0, up_data.d};
         data_in.lane[l].r  = take ? NW'(trial - {1'b0, up_data.d}) : trial[NW-1:0];
         data_in.lane[l].sh = {up_data.lane[l].sh[ST-2:0], take};
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/segment_intersection_top.sv =====
// Segment intersection: from req transfer to rsp_valid a pair passes through
// 5 front stages, 16 division cells and 1 output register, with an idle output.
// One pair per cycle while rsp_ready is high; the valid/ready chain fills bubbles.
// Reset (synchronous) clears only the stage valid bits; data registers keep junk.
// Depends on sgi_pkg, sgi_front, sgi_div_cell and the defines header.
`timescale 1ns / 1ps
`include "segment_intersection_top_defines.svh"
module segment_intersection_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sgi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sgi_pkg::rsp_type rsp_data
);

   localparam int ST = sgi_pkg::STEPS;
   localparam int CW = sgi_pkg::COORD_WIDTH;
   localparam int FB = sgi_pkg::PARAM_FRAC_BITS;

   // chain of division cells; index 0 is the front's output
   sgi_pkg::cell_type chain_data [0:ST];
   logic [ST:0]       chain_valid;
   logic [ST:0]       chain_ready;

   sgi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .dn_valid  (chain_valid[0]),
      .dn_ready  (chain_ready[0]),
      .dn_data   (chain_data[0])
   );

   // each cell resolves one quotient bit of s, t and the two point offsets
   for (genvar i = 0; i < ST; i++) begin : g_cell
      sgi_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_ready (chain_ready[i]),
         .up_data  (chain_data[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_ready (chain_ready[i+1]),
         .dn_data  (chain_data[i+1])
      );
   end

   // output register; the last cell hands over a result only as the waiting one leaves
   logic             rsp_valid_ff;
   sgi_pkg::rsp_type rsp_data_ff;
   sgi_pkg::rsp_type rsp_data_in;

   assign chain_ready[ST] = !rsp_valid_ff || rsp_ready;

   always_comb begin
      logic [CW-1:0] qx, qy, offx, offy;
      qx   = chain_data[ST].lane[sgi_pkg::LANE_X].sh[ST-1 -: CW];
      qy   = chain_data[ST].lane[sgi_pkg::LANE_Y].sh[ST-1 -: CW];
      offx = chain_data[ST].ax_neg ? -qx : qx;
      offy = chain_data[ST].ay_neg ? -qy : qy;
      rsp_data_in = '0;
      if (chain_data[ST].hit) begin
         rsp_data_in.hit       = 1'b1;
         rsp_data_in.frac_on_b = chain_data[ST].lane[sgi_pkg::LANE_S].sh[ST-1 -: FB];
         rsp_data_in.frac_on_a = chain_data[ST].lane[sgi_pkg::LANE_T].sh[ST-1 -: FB];
         rsp_data_in.cross_x   = chain_data[ST].p0x + offx;
         rsp_data_in.cross_y   = chain_data[ST].p0y + offy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_ready[ST]) begin
         rsp_valid_ff <= chain_valid[ST];
      end
   end

   always_ff @(posedge clock) begin
      if (chain_ready[ST] && chain_valid[ST]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a miss carries all-zero result fields
   `SGI_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_data.hit, (rsp_data.frac_on_b == '0) && (rsp_data.frac_on_a == '0) && (rsp_data.cross_x == '0) && (rsp_data.cross_y == '0), "miss with nonzero fields")
   // an empty output register lets the whole pipeline advance
   `SGI_ASSERT_IMPLY(a_ready_free, clock, reset, !rsp_valid, req_ready, "input stalled with empty output")
   // nothing is offered right after reset
   `SGI_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_valid, "result valid after reset")

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for segment_intersection_top: streams segment pairs,
// predicts hit, fractions and crossing point, and compares each rsp transfer.
// Depends on sgi_pkg and the segment_intersection_top RTL.
`timescale 1ns / 1ps
module tb_top;

   localparam int RANDOM_N   = 400;
   localparam int DRAIN_CYC  = 60;
   // worst case per item: send gap plus receive stall plus pipeline depth
   localparam longint CYCLE_LIMIT = 64'd200000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   sgi_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   sgi_pkg::rsp_type rsp_data;

   sgi_pkg::req_type pending_pairs[$];     // pairs waiting to be driven
   sgi_pkg::rsp_type expected_hits[$];     // predicted results, oldest first
   int      mismatch_cnt;
   longint  cycle_cnt;
   int      send_gap;
   int      recv_gap;
   bit      stim_done;

   segment_intersection_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Restoring division giving a Q0.16 fraction; num in [0, den)
   function automatic logic [sgi_pkg::PARAM_FRAC_BITS-1:0] div_frac(longint num,
                                                                    longint den);
      longint rem;
      logic [sgi_pkg::PARAM_FRAC_BITS-1:0] q;
      rem = num;
      q = '0;
      for (int i = 0; i < sgi_pkg::PARAM_FRAC_BITS; i++) begin
         rem = rem <<< 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // start + trunc(dir * num / den), wrapped to coordinate width
   function automatic logic [sgi_pkg::COORD_WIDTH-1:0] point_along(longint start,
                                                                   longint dir,
                                                                   longint num,
                                                                   longint den);
      longint mag;
      longint q;
      mag = (dir < 0) ? -dir : dir;
      q = (num * mag) / den;
      if (dir < 0) q = -q;
      return sgi_pkg::COORD_WIDTH'(start + q);
   endfunction

   function automatic sgi_pkg::rsp_type predict_crossing(sgi_pkg::req_type p);
      longint ax, ay, bx, by, wx, wy, den, sn, tn, sd, td;
      bit hit;
      sgi_pkg::rsp_type r;
      ax = longint'(p.a_end_x) - longint'(p.a_start_x);
      ay = longint'(p.a_end_y) - longint'(p.a_start_y);
      bx = longint'(p.b_end_x) - longint'(p.b_start_x);
      by = longint'(p.b_end_y) - longint'(p.b_start_y);
      wx = longint'(p.a_start_x) - longint'(p.b_start_x);
      wy = longint'(p.a_start_y) - longint'(p.b_start_y);
      den = ax * by - bx * ay;
      sn = ax * wy - ay * wx;
      tn = bx * wy - by * wx;
      sd = den;
      td = den;
      hit = 1'b1;
      r = '0;
      if ((sn < 0 && sd > 0) || (sn > 0 && sd < 0)) hit = 1'b0;
      if (sn < 0) begin
         sn = -sn;
         sd = -sd;
      end
      if ((tn < 0 && td > 0) || (tn > 0 && td < 0)) hit = 1'b0;
      if (tn < 0) begin
         tn = -tn;
         td = -td;
      end
      if (hit && sn < sd && tn < td) begin
         r.hit = 1'b1;
         r.frac_on_b = div_frac(sn, sd);
         r.frac_on_a = div_frac(tn, td);
         r.cross_x = point_along(p.a_start_x, ax, tn, td);
         r.cross_y = point_along(p.a_start_y, ay, tn, td);
      end
      return r;
   endfunction

   function automatic sgi_pkg::req_type make_pair(int ax0, int ay0, int ax1, int ay1,
                                                  int bx0, int by0, int bx1, int by1);
      sgi_pkg::req_type p;
      p.a_start_x = 16'(ax0);
      p.a_start_y = 16'(ay0);
      p.a_end_x   = 16'(ax1);
      p.a_end_y   = 16'(ay1);
      p.b_start_x = 16'(bx0);
      p.b_start_y = 16'(by0);
      p.b_end_x   = 16'(bx1);
      p.b_end_y   = 16'(by1);
      return p;
   endfunction

   // Random crossing pair: a box of random size, either fully random points
   // or two diagonals through a random box so a hit is likely.
   function automatic sgi_pkg::req_type random_pair();
      int span;
      int cx, cy;
      sgi_pkg::req_type p;
      case ($urandom_range(0, 3))
         0: begin
            p = sgi_pkg::req_type'({$urandom, $urandom, $urandom, $urandom});
         end
         default: begin
            span = (1 << $urandom_range(2, 15)) - 1;
            cx = $signed(16'($urandom)) / 2;
            cy = $signed(16'($urandom)) / 2;
            p = make_pair(cx - $urandom_range(0, span) / 2, cy - $urandom_range(0, span) / 2,
                          cx + $urandom_range(0, span) / 2, cy + $urandom_range(0, span) / 2,
                          cx - $urandom_range(0, span) / 2, cy + $urandom_range(0, span) / 2,
                          cx + $urandom_range(0, span) / 2, cy - $urandom_range(0, span) / 2);
         end
      endcase
      return p;
   endfunction

   initial begin
      // simple X crossing, hit at the middle
      pending_pairs.push_back(make_pair(0, 0, 160, 160, 0, 160, 160, 0));
      // reversed B direction
      pending_pairs.push_back(make_pair(0, 0, 160, 160, 160, 0, 0, 160));
      // parallel segments: zero denominator
      pending_pairs.push_back(make_pair(0, 0, 160, 0, 0, 16, 160, 16));
      // collinear overlap, everything zero
      pending_pairs.push_back(make_pair(0, 0, 160, 0, 32, 0, 200, 0));
      // crossing exactly at A start: t = 0
      pending_pairs.push_back(make_pair(0, 0, 160, 0, 0, -16, 0, 16));
      // crossing exactly at A end: t = 1, no hit
      pending_pairs.push_back(make_pair(0, 0, 160, 0, 160, -16, 160, 16));
      // zero numerator with negative denominator
      pending_pairs.push_back(make_pair(0, 0, 160, 0, 0, 16, 0, -16));
      // miss: lines cross outside the segments (sign conflict)
      pending_pairs.push_back(make_pair(0, 0, 16, 16, 100, 0, 200, -100));
      // degenerate point segments
      pending_pairs.push_back(make_pair(5, 5, 5, 5, 5, 5, 5, 5));
      // full-range extremes
      pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                        -32768, 32767, 32767, -32768));
      pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767,
                                        -32768, -32768, 32767, 32767));
      pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
      pending_pairs.push_back(make_pair(32767, 32767, -32768, -32768,
                                        32767, -32768, -32768, 32767));
      pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
      // negative direction components, off-center point with truncation
      pending_pairs.push_back(make_pair(100, 50, -300, -170, -200, 90, 150, -120));
      pending_pairs.push_back(make_pair(-7, 3, 13, -29, 11, 17, -19, -23));
      // near-parallel, tiny denominator
      pending_pairs.push_back(make_pair(0, 0, 32767, 1, 0, 1, 32767, 0));
      pending_pairs.push_back(make_pair(-32768, -1, 32767, 0, -32768, 0, 32767, -1));
      pending_pairs.push_back(make_pair(0, 0, 3, 1, 1, 0, 0, 1));
      pending_pairs.push_back(make_pair(1, 0, 0, 1, 0, 0, 3, 1));
      for (int i = 0; i < RANDOM_N; i++) pending_pairs.push_back(random_pair());
   end

   // Driver: hold each pair until its transfer, then wait a random gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= $urandom_range(0, 19);
      end else if (req_valid && !req_ready) begin
         // hold the pair
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (pending_pairs.size() > 0) begin
         req_valid <= 1'b1;
         req_data  <= pending_pairs.pop_front();
         // one third of pairs go back to back
         send_gap  <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
      end else begin
         req_valid <= 1'b0;
         stim_done <= 1'b1;
      end
      if (!reset && req_valid && req_ready)
         expected_hits.push_back(predict_crossing(req_data));
   end

   // Monitor: random receive stalls and field-by-field comparison
   always @(posedge clock) begin
      sgi_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= $urandom_range(0, 19);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               mismatch_cnt <= mismatch_cnt + 1;
               if (mismatch_cnt < 10)
                  $display("unexpected rsp transfer: %p", rsp_data);
            end else begin
               want = expected_hits.pop_front();
               if (want.hit !== rsp_data.hit || want.frac_on_b !== rsp_data.frac_on_b ||
                   want.frac_on_a !== rsp_data.frac_on_a ||
                   want.cross_x !== rsp_data.cross_x || want.cross_y !== rsp_data.cross_y) begin
                  mismatch_cnt <= mismatch_cnt + 1;
                  if (mismatch_cnt < 10)
                     $display("rsp mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
         if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap  <= recv_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid)
               recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      mismatch_cnt = 0;
      cycle_cnt    = 0;
      stim_done    = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && expected_hits.size() == 0);
      // catch any stray extra responses
      repeat (DRAIN_CYC) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
